>>> rtl/core/cma_pkg.sv
// Shared types and constants for the centered moving average block.
package cma_pkg;

  // Width of the half_width configuration register.
  localparam int HW_W = 3;

  // The widest window is twice the largest half width plus one, so a divisor fits in four bits.
  localparam int DIV_W = 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DIV
  } state_t;

endpackage

>>> rtl/core/cma_cell.sv
// One cell of the sample line: holds one sample and a running prefix sum.
module cma_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 20
) (
  input  logic                          clk,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [SUM_W-1:0]       psum_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic signed [SUM_W-1:0]       psum_out
);

  // The sample moves one cell down the line on every accepted beat. The prefix sum
  // ripples one cell per clock, so it is settled once the line has stopped moving
  // and the ripple has reached this cell.
  always_ff @(posedge clk) begin
    if (shift) begin
      sample_out <= sample_in;
    end
    psum_out <= psum_in + SUM_W'(sample_out);
  end

endmodule

>>> rtl/core/cma_div.sv
// Signed by small unsigned divider, one quotient bit per cycle, truncating toward zero.
module cma_div #(
  parameter int SUM_W = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic [cma_pkg::DIV_W-1:0]  divisor,
  output logic                       busy,
  output logic signed [SUM_W-1:0]    quotient
);
  import cma_pkg::*;

  localparam int MAG_W = SUM_W - 1;
  localparam int CW    = $clog2(MAG_W + 1);

  logic [SUM_W-1:0] abs_full;
  logic [MAG_W-1:0] dq;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign abs_full = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial    = {rem, dq[MAG_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= abs_full[MAG_W-1:0];
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[SUM_W-1];
      cnt <= CW'(MAG_W);
    end else if (busy) begin
      rem <= ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      dq  <= {dq[MAG_W-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

endmodule

>>> rtl/core/centered_moving_average.sv
// Top level of the centered moving average filter.
//
// Usage: samples enter on the sample channel (sample_valid, sample_stall) with
// last_sample set on the final sample of a signal. Each result on the average
// channel (average_valid, average_stall) is the mean of the samples from
// half_width before to half_width after its position, truncated toward zero,
// with the window cut at either end of the signal. A sample that completes a
// window yields one result; a final sample yields up to half_width + 1 results,
// the last of them with last_result set, and the next beat starts a new signal.
// half_width must be written on the configuration channel (cfg_valid, cfg_ready)
// only while idle; the block does not enforce this, as cfg_ready is always high.
// A sample that yields no result is taken at once and leaves the block idle.
// For each result the sequencer waits until the prefix sum at tap far has
// settled, where far + 1 is the window size (at most 2*half_width + 1): the
// prefix sums ripple down the sample line one cell per cycle. The divider then
// retires one quotient bit per cycle. One sample is processed at a time;
// sample_stall stays high until its last result is loaded.
// The output register lets a new sample in while a result waits to be taken.
// Reset is synchronous: half_width returns to 1 and the signal restarts empty.
// A stalled result holds its value until the receiver takes it.
module centered_moving_average #(
  parameter int MAX_HALF    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cma_pkg::HW_W-1:0]      half_width,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_sample,
  output logic                          average_valid,
  input  logic                          average_stall,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic                          last_result
);
  import cma_pkg::*;

  localparam int HIST  = 2 * MAX_HALF + 1;
  localparam int IDX_W = $clog2(HIST);
  localparam int CNT_W = $clog2(HIST + 1);
  localparam int SUM_W = SAMPLE_BITS + DIV_W;
  localparam int HMAX  = (1 << HW_W) - 1;
  localparam int HCAP  = (MAX_HALF < HMAX) ? MAX_HALF : HMAX;

  state_t state, state_next;

  logic [HW_W-1:0]  hw_reg;
  logic [CNT_W-1:0] h_eff;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] n_new;
  logic [CNT_W-1:0] n_reg;
  logic [CNT_W-1:0] d_start;
  logic [CNT_W-1:0] d_reg;
  logic [CNT_W-1:0] settle;
  logic [CNT_W-1:0] dh;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] far_full;
  logic             last_reg;
  logic             acc;
  logic             go;
  logic             job_done;
  logic             last_now;
  logic             out_free;
  logic             out_load;
  logic             div_start;
  logic             div_busy;

  logic signed [SAMPLE_BITS-1:0] sample_link [HIST+1];
  logic signed [SUM_W-1:0]       psum_link   [HIST+1];
  logic signed [SUM_W-1:0]       psum_tap    [HIST];
  logic signed [SUM_W-1:0]       div_quot;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hw_reg <= HW_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      hw_reg <= half_width;
    end
  end

  // A half width beyond what the sample line holds acts as the largest one.
  assign h_eff = (hw_reg > HW_W'(HCAP)) ? CNT_W'(HCAP) : CNT_W'(hw_reg);

  assign acc   = sample_valid && !sample_stall;
  assign n_new = (seen < CNT_W'(HIST)) ? seen + CNT_W'(1) : seen;

  // A middle sample emits the position half_width back from the newest sample.
  // A final sample emits every pending position, from that one down to the newest.
  // Both are served by the same job: far = min(d + h, n - 1), divisor far + 1.
  assign d_start = (!last_sample) ? h_eff :
                   ((n_new - CNT_W'(1) < h_eff) ? n_new - CNT_W'(1) : h_eff);
  assign go      = last_sample || (n_new > h_eff);

  assign dh       = d_reg + h_eff;
  assign n_m1     = n_reg - CNT_W'(1);
  assign far_full = (dh < n_m1) ? dh : n_m1;
  assign job_done = !last_reg || (d_reg == '0);
  assign last_now = last_reg && (d_reg == '0);
  assign out_free = !average_valid || !average_stall;

  // Sample line: cell k holds the sample k beats old and the sum of cells 0..k.
  assign sample_link[0] = sample;
  assign psum_link[0]   = '0;

  for (genvar k = 0; k < HIST; k++) begin : g_cell
    cma_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_W      (SUM_W)
    ) u_cell (
      .clk       (clk),
      .shift     (acc),
      .sample_in (sample_link[k]),
      .psum_in   (psum_link[k]),
      .sample_out(sample_link[k+1]),
      .psum_out  (psum_link[k+1])
    );
    assign psum_tap[k] = psum_link[k+1];
  end

  cma_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(psum_tap[far_full[IDX_W-1:0]]),
    .divisor (DIV_W'(far_full) + DIV_W'(1)),
    .busy    (div_busy),
    .quotient(div_quot)
  );

  // Sequencer: wait for the prefix sum to settle, divide, then hand the result over.
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    out_load     = 1'b0;
    sample_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid && go) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (settle > far_full) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          out_load   = 1'b1;
          state_next = job_done ? S_IDLE : S_WAIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sample count of the current signal, and cycles since the line last moved.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      settle <= '0;
    end else begin
      if (acc) begin
        seen   <= last_sample ? '0 : n_new;
        settle <= '0;
      end else if (settle < CNT_W'(HIST)) begin
        settle <= settle + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      n_reg    <= n_new;
      last_reg <= last_sample;
      d_reg    <= d_start;
    end else if (out_load && !job_done) begin
      d_reg <= d_reg - CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (out_load) begin
      average_valid <= 1'b1;
    end else if (!average_stall) begin
      average_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average     <= div_quot[SAMPLE_BITS-1:0];
      last_result <= last_now;
    end
  end

  // A result is never loaded over a beat the receiver has not taken yet.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(average_valid && average_stall))
    else $error("result loaded over a stalled beat");

  // New samples are only taken while the divider is idle.
  a_div_idle_on_accept : assert property (@(posedge clk) disable iff (rst)
    acc |-> !div_busy)
    else $error("sample accepted while divider busy");

  // A final sample restarts the signal count.
  a_flush_restart : assert property (@(posedge clk) disable iff (rst)
    (acc && last_sample) |=> (seen == '0))
    else $error("sample count not cleared after final sample");

  // The final result of a flush returns the sequencer to idle.
  a_last_to_idle : assert property (@(posedge clk) disable iff (rst)
    (out_load && last_now) |=> (state == S_IDLE))
    else $error("sequencer not idle after final result");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the centered moving average filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cma_pkg::*;

  localparam int MAX_HALF     = 7;
  localparam int SAMPLE_BITS  = 16;
  localparam int HIST_DEPTH   = 2 * MAX_HALF + 1;
  localparam int RANDOM_BEATS = 190;
  // Receiver hold-off long enough for the block to back up and stall its input.
  localparam int HOLD_CYCLES  = 400;
  // A beat that yields no average retires at once, but a result waits for the
  // widest window to settle and for the serial divider; this covers both.
  localparam int DRAIN_GUARD  = 48;
  localparam int TAIL_CYCLES  = 60;
  // Longest legal quiet spell is the hold-off plus a drain; several times that.
  localparam int STALL_LIMIT  = 2000;
  localparam int NUM_DIRECTED = 27;

  typedef logic signed [SAMPLE_BITS-1:0] q88_t;

  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_CFG
  } row_kind_t;

  // One directed step. For a configuration row, value carries the half width.
  // Where typed is set, the row yields exactly one average that is given here.
  typedef struct packed {
    row_kind_t                     kind;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          fin;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] avg;
    logic                          avg_fin;
  } step_row_t;

  typedef struct {
    q88_t avg;
    logic fin;
  } avg_result_t;

  localparam step_row_t DIRECTED [NUM_DIRECTED] = '{
    // Reset window (half width 1). One-sample signals at both extremes return
    // the sample itself, flagged as the final output.
    '{ROW_BEAT, 16'sd32767,  1'b1, 1'b1, 16'sd32767, 1'b1},
    '{ROW_BEAT, 16'h8000,    1'b1, 1'b1, 16'h8000,   1'b1},
    // The first beat is too early to complete a window; the final beat flushes.
    '{ROW_BEAT, 16'sd100,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd200,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd300,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, -16'sd7,     1'b1, 1'b0, 16'sd0,     1'b0},
    // Zero half width: every average is just its own sample.
    '{ROW_CFG,  16'sd0,      1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd5,      1'b0, 1'b1, 16'sd5,     1'b0},
    '{ROW_BEAT, -16'sd3,     1'b1, 1'b1, -16'sd3,    1'b1},
    // The window shrinks from 7 to 3 in the middle of a signal.
    '{ROW_CFG,  16'sd3,      1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd10,     1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd20,     1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd30,     1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd41,     1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_CFG,  16'sd1,      1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd50,     1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, -16'sd60,    1'b1, 1'b0, 16'sd0,     1'b0},
    // Widest window with full-scale samples: largest sums, longest flush, and
    // negative means that must truncate toward zero.
    '{ROW_CFG,  16'sd7,      1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd32767,  1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd32767,  1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd32767,  1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'sd32767,  1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'h8000,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'h8000,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'h8000,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, 16'h8000,    1'b0, 1'b0, 16'sd0,     1'b0},
    '{ROW_BEAT, -16'sd1,     1'b1, 1'b0, 16'sd0,     1'b0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [HW_W-1:0]   half_width;
  logic              sample_valid;
  logic              sample_stall;
  q88_t              sample;
  logic              last_sample;
  logic              average_valid;
  logic              average_stall;
  q88_t              average;
  logic              last_result;

  centered_moving_average #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .half_width   (half_width),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .last_sample  (last_sample),
    .average_valid(average_valid),
    .average_stall(average_stall),
    .average      (average),
    .last_result  (last_result)
  );

  // Our own copy of the filter state: recent samples newest first, the count
  // of samples in the current signal (saturating), and the window setting.
  q88_t            recent_samples [HIST_DEPTH];
  int              signal_len_seen;
  logic [HW_W-1:0] window_half;

  // Averages still owed by the block, oldest first.
  avg_result_t expected_avgs [$];

  int  mismatches;
  int  beats_sent;
  int  random_beats;
  int  signals_done;
  int  results_checked;
  int  cfg_writes;
  int  holds_done;
  int  idle_cycles;
  // A quiet phase runs both sides with no gaps at all.
  bit  quiet;
  // Set by the sender to make the receiver hold off for a long stretch.
  bit  hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mean of the newest far+1 samples; SystemVerilog division truncates
  // toward zero, which is exactly what the block must do.
  function automatic q88_t window_mean(int far);
    longint total;
    int     k;
    total = 0;
    for (k = 0; k <= far; k++) total += recent_samples[k];
    return q88_t'(total / longint'(far + 1));
  endfunction

  // Advance the filter state by one accepted beat and queue the averages it
  // releases. A non-final beat releases the position half a window back once
  // enough samples exist; a final beat flushes every pending position.
  task automatic predict_averages(input q88_t s, input logic fin, input bit record);
    int h;
    int cnt;
    int pend;
    int far;
    int d;
    int k;
    h = (window_half > MAX_HALF) ? MAX_HALF : int'(window_half);
    for (k = HIST_DEPTH - 1; k > 0; k--) recent_samples[k] = recent_samples[k-1];
    recent_samples[0] = s;
    if (signal_len_seen < HIST_DEPTH) signal_len_seen++;
    if (!fin) begin
      if (signal_len_seen > h) begin
        cnt = (signal_len_seen < 2 * h + 1) ? signal_len_seen : 2 * h + 1;
        if (record) expected_avgs.push_back(avg_result_t'{window_mean(cnt - 1), 1'b0});
      end
    end else begin
      pend = (signal_len_seen < h + 1) ? signal_len_seen : h + 1;
      for (d = pend - 1; d >= 0; d--) begin
        far = d + h;
        if (far > signal_len_seen - 1) far = signal_len_seen - 1;
        if (record) expected_avgs.push_back(avg_result_t'{window_mean(far), d == 0});
      end
      for (k = 0; k < HIST_DEPTH; k++) recent_samples[k] = '0;
      signal_len_seen = 0;
    end
  endtask

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(4, 25);
  endfunction

  // Full-scale values and small values near zero are favored, so that both
  // the largest sums and the rounding of small negative means get hit.
  function automatic q88_t random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return q88_t'(16'sd32767);
    else if (r == 1) return q88_t'(16'h8000);
    else if (r < 5) return q88_t'($urandom_range(0, 200) - 100);
    else return q88_t'($urandom);
  endfunction

  // Signals of one sample, typical lengths, and long ones, most of which fill
  // the history completely.
  function automatic int pick_signal_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    else if (r < 70) return $urandom_range(2, 12);
    else return $urandom_range(13, 40);
  endfunction

  // Both ends of the range come up often; anything in between otherwise.
  function automatic logic [HW_W-1:0] pick_half();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    else if (r == 1) return '1;
    else return HW_W'($urandom_range(0, 7));
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s of average %0d: got %0d, expected %0d",
             field, results_checked, got, want);
    mismatches++;
  endtask

  // Offer one sample beat and hold it until the block takes it. The call
  // starts and ends at a falling edge, so valid stays high between beats that
  // follow each other with no gap.
  task automatic send_beat(input q88_t s, input logic fin, input logic typed,
                           input q88_t t_avg, input logic t_fin);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    last_sample  <= fin;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_averages(s, fin, !typed);
    if (typed) expected_avgs.push_back(avg_result_t'{t_avg, t_fin});
    beats_sent++;
    if (fin) signals_done++;
    @(negedge clk);
  endtask

  // The sender stops and waits for every owed average, then lets the block
  // settle, so the window can be changed while it is idle.
  task automatic drain_outputs();
    sample_valid <= 1'b0;
    while (expected_avgs.size() != 0) @(negedge clk);
    repeat (DRAIN_GUARD) @(negedge clk);
  endtask

  task automatic write_half_width(input logic [HW_W-1:0] value);
    drain_outputs();
    cfg_valid  <= 1'b1;
    half_width <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_half = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: reset, the directed table, then random phases. Each phase picks
  // a new window (so some signals see the window change midway), and every
  // fourth phase runs without gaps on either side.
  initial begin
    int   k;
    int   phase;
    int   phase_len;
    int   remaining;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    half_width   = HW_W'(1);
    sample_valid = 1'b0;
    sample       = '0;
    last_sample  = 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    for (k = 0; k < HIST_DEPTH; k++) recent_samples[k] = '0;
    signal_len_seen = 0;
    window_half     = HW_W'(1);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      if (DIRECTED[k].kind == ROW_CFG) begin
        write_half_width(DIRECTED[k].value[HW_W-1:0]);
      end else begin
        send_beat(DIRECTED[k].value, DIRECTED[k].fin, DIRECTED[k].typed,
                  DIRECTED[k].avg, DIRECTED[k].avg_fin);
      end
    end

    phase     = 0;
    remaining = 0;
    while (random_beats < RANDOM_BEATS) begin
      write_half_width(pick_half());
      quiet = (phase % 4 == 1);
      // Early on, the receiver holds off while this phase keeps offering beats.
      if (phase == 2) hold_request = 1'b1;
      phase_len = $urandom_range(8, 30);
      for (k = 0; k < phase_len && random_beats < RANDOM_BEATS; k++) begin
        if (remaining == 0) remaining = pick_signal_len();
        remaining--;
        send_beat(random_sample(), remaining == 0, 1'b0, '0, 1'b0);
        random_beats++;
      end
      phase++;
    end
    // Close the signal that is still open, cutting it short.
    if (remaining > 0) send_beat(random_sample(), 1'b1, 1'b0, '0, 1'b0);
    quiet = 1'b0;

    sample_valid <= 1'b0;
    while (expected_avgs.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d sample beats in %0d signals over %0d window settings; checked %0d averages.",
             beats_sent, signals_done, cfg_writes, results_checked);
    $display("The receiver held off for %0d long stretches besides its random gaps.",
             holds_done);
    if (mismatches == 0) begin
      $display("** centered_moving_average: PASSED **");
    end else begin
      $display("** centered_moving_average: FAILED **");
    end
    $finish;
  end

  // Receiver: random stalls, none in quiet phases, and the long hold-off on
  // request, counted here in its own cycles.
  initial begin
    int gap;
    average_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        average_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
          average_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
        average_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Every average the block hands over is matched against the oldest one owed.
  always @(posedge clk) begin : check_averages
    avg_result_t want;
    if (!rst && average_valid && !average_stall) begin
      if (expected_avgs.size() == 0) begin
        report_mismatch("presence", 1, 0);
      end else begin
        want = expected_avgs.pop_front();
        if (average !== want.avg) report_mismatch("value", int'(average), int'(want.avg));
        if (last_result !== want.fin) begin
          report_mismatch("last flag", int'(last_result), int'(want.fin));
        end
      end
      results_checked++;
    end
  end

  // Watchdog: the run is hung once no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (average_valid && !average_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d averages still owed",
               idle_cycles, expected_avgs.size());
      $display("** centered_moving_average: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
